// File: rtl/core/q4bda_pkg.sv
`default_nettype none

package q4bda_pkg;

    // Field and accumulator widths.
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned ACT_W     = 16;
    localparam int unsigned SCALE_W   = 16;
    localparam int unsigned NIB_W     = 4;
    localparam int unsigned PAIR_W    = NIB_W + ACT_W;        // one 4 x 16 product
    localparam int unsigned PARTIAL_W = 25;                   // block partial sum
    localparam int unsigned SUM_W     = PARTIAL_W + 1;        // partial plus two products
    localparam int unsigned PROD_W    = PARTIAL_W + SCALE_W;  // partial times scale
    localparam int unsigned ACC_W     = 64;                   // row accumulator
    localparam int unsigned OUT_W     = 48;                   // emitted result

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // input transfer: add the two products to the block partial
        logic scale;    // multiply the block partial by the captured scale
        logic accum;    // add the scaled block into the row accumulator
        logic emit;     // load the output register and clear the accumulator
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // output register can take a new result this cycle
    } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/q4bda_ctrl.sv
`default_nettype none

module q4bda_ctrl
    import q4bda_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  end_of_block,
    input  wire logic  end_of_row,
    input  wire stat_t stat,
    output logic       in_stall,
    output cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCALE = 2'd1;
    localparam logic [1:0] ST_ACCUM = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       row_end_reg;
    logic       row_end_next;
    logic       accept;

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next   = state_reg;
        row_end_next = row_end_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = accept;
                if (accept && (end_of_block || end_of_row))
                begin
                    state_next   = ST_SCALE;
                    row_end_next = end_of_row;
                end
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                cmd.accum  = 1'b1;
                state_next = row_end_reg ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_end_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_end_reg <= row_end_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/q4bda_datapath.sv
`default_nettype none

module q4bda_datapath
    import q4bda_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cmd_t                      cmd,
    input  wire logic        [BYTE_W-1:0]  packed_byte,
    input  wire logic signed [ACT_W-1:0]   act_even,
    input  wire logic signed [ACT_W-1:0]   act_odd,
    input  wire logic signed [SCALE_W-1:0] block_scale,
    input  wire logic                      out_stall,
    output stat_t                          stat,
    output logic                           out_valid,
    output logic signed [OUT_W-1:0]        row_dot
);

    localparam logic signed [PARTIAL_W-1:0] PARTIAL_MAX = {1'b0, {(PARTIAL_W-1){1'b1}}};
    localparam logic signed [PARTIAL_W-1:0] PARTIAL_MIN = {1'b1, {(PARTIAL_W-1){1'b0}}};
    localparam logic signed [ACC_W-1:0]     ACC_MAX     = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]     ACC_MIN     = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0]     OUT_MAX     = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0]     OUT_MIN     = {1'b1, {(OUT_W-1){1'b0}}};

    logic signed [PARTIAL_W-1:0] partial_reg;
    logic signed [PARTIAL_W-1:0] partial_next;
    logic signed [SCALE_W-1:0]   scale_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [ACC_W-1:0]     acc_next;
    logic signed [OUT_W-1:0]     row_dot_reg;
    logic                        out_valid_reg;

    logic signed [NIB_W-1:0]     w_lo;
    logic signed [NIB_W-1:0]     w_hi;
    logic signed [PAIR_W-1:0]    p_lo;
    logic signed [PAIR_W-1:0]    p_hi;
    logic signed [SUM_W-1:0]     mac_sum;
    logic signed [ACC_W-1:0]     acc_addend;
    logic signed [ACC_W-1:0]     acc_sum;
    logic                        acc_ovf;
    logic                        out_fits;
    logic signed [OUT_W-1:0]     out_sat;

    // A nibble minus 8 is the nibble with its top bit inverted, read as signed.
    assign w_lo = {~packed_byte[3], packed_byte[2:0]};
    assign w_hi = {~packed_byte[7], packed_byte[6:4]};
    assign p_lo = w_lo * act_even;
    assign p_hi = w_hi * act_odd;

    assign mac_sum = {partial_reg[PARTIAL_W-1], partial_reg}
                   + {{(SUM_W-PAIR_W){p_lo[PAIR_W-1]}}, p_lo}
                   + {{(SUM_W-PAIR_W){p_hi[PAIR_W-1]}}, p_hi};

    always_comb
    begin
        partial_next = partial_reg;
        if (cmd.accept)
        begin
            if (mac_sum[SUM_W-1] != mac_sum[SUM_W-2])
            begin
                partial_next = mac_sum[SUM_W-1] ? PARTIAL_MIN : PARTIAL_MAX;
            end
            else
            begin
                partial_next = mac_sum[PARTIAL_W-1:0];
            end
        end
        else if (cmd.scale)
        begin
            partial_next = '0;
        end
    end

    // Saturating 64-bit add of the scaled block.
    assign acc_addend = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign acc_sum    = acc_reg + acc_addend;
    assign acc_ovf    = (acc_reg[ACC_W-1] == acc_addend[ACC_W-1])
                     && (acc_sum[ACC_W-1] != acc_reg[ACC_W-1]);

    always_comb
    begin
        acc_next = acc_reg;
        if (cmd.accum)
        begin
            if (acc_ovf)
            begin
                acc_next = acc_reg[ACC_W-1] ? ACC_MIN : ACC_MAX;
            end
            else
            begin
                acc_next = acc_sum;
            end
        end
        else if (cmd.emit)
        begin
            acc_next = '0;
        end
    end

    // The accumulator fits the output when its upper bits all equal the sign.
    assign out_fits = (&acc_reg[ACC_W-1:OUT_W-1]) || !(|acc_reg[ACC_W-1:OUT_W-1]);
    assign out_sat  = out_fits ? acc_reg[OUT_W-1:0]
                               : (acc_reg[ACC_W-1] ? OUT_MIN : OUT_MAX);

    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg   <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            partial_reg <= partial_next;
            acc_reg     <= acc_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            scale_reg <= block_scale;
        end
        if (cmd.scale)
        begin
            prod_reg <= partial_reg * scale_reg;
        end
        if (cmd.emit)
        begin
            row_dot_reg <= out_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_dot   = row_dot_reg;

endmodule

`default_nettype wire

// File: rtl/core/q4_block_dot_accumulate.sv
// Dot product of one row of 4-bit block-quantized weights against one row of
// already rotated Q7.8 activations. Each input transfer carries one packed
// weight byte (low nibble pairs with act_even, high nibble with act_odd; each
// nibble has 8 subtracted) together with the two activations. The two products
// are added into a 25-bit block partial sum that saturates. A transfer with
// end_of_block or end_of_row closes the block: the partial sum is multiplied by
// that transfer's Q3.12 block_scale and added into a saturating 64-bit row
// accumulator with 20 fraction bits. A transfer with end_of_row then produces
// one result transfer, row_dot, saturated to 48 bits, and clears the
// accumulator. Timing: bytes that do not close a block stream back to back.
// A byte that closes a block holds the input stalled through the registered
// partial-by-scale multiply and then the 64-bit accumulator add. A byte that
// ends a row also keeps the input stalled while the output register is
// loaded, and for as long as the previous result still waits there under
// out_stall. The output register lets new bytes be accepted while a finished
// result waits to be taken.
`default_nettype none

module q4_block_dot_accumulate
    import q4bda_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic        [BYTE_W-1:0]  packed_byte,
    input  wire logic signed [ACT_W-1:0]   act_even,
    input  wire logic signed [ACT_W-1:0]   act_odd,
    input  wire logic signed [SCALE_W-1:0] block_scale,
    input  wire logic                      end_of_block,
    input  wire logic                      end_of_row,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [OUT_W-1:0]        row_dot
);

    cmd_t  cmd;
    stat_t stat;

    // The controller sequences each transfer through multiply-accumulate and,
    // at a block or row end, block scaling, accumulation and result hand-off.
    q4bda_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .end_of_block (end_of_block),
        .end_of_row   (end_of_row),
        .stat         (stat),
        .in_stall     (in_stall),
        .cmd          (cmd)
    );

    // The datapath holds the block partial, the row accumulator and the
    // output register.
    q4bda_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .packed_byte (packed_byte),
        .act_even    (act_even),
        .act_odd     (act_odd),
        .block_scale (block_scale),
        .out_stall   (out_stall),
        .stat        (stat),
        .out_valid   (out_valid),
        .row_dot     (row_dot)
    );

endmodule

`default_nettype wire

// File: rtl/core/q4bda_checker.sv
`default_nettype none

module q4bda_checker
    import q4bda_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic        [BYTE_W-1:0]  packed_byte,
    input wire logic signed [ACT_W-1:0]   act_even,
    input wire logic signed [ACT_W-1:0]   act_odd,
    input wire logic signed [SCALE_W-1:0] block_scale,
    input wire logic                      end_of_block,
    input wire logic                      end_of_row,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic signed [OUT_W-1:0]   row_dot
);

    logic in_xfer;

    assign in_xfer = in_valid && !in_stall;

    // A waiting result stays put until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_dot))
        else $error("result changed or vanished while stalled");

    // Bytes inside a block stream without a stall.
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !end_of_block && !end_of_row |=> !in_stall)
        else $error("input stalled after a byte inside a block");

    // A block close without a row end stalls only the scale and accumulate states.
    a_block_close: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && end_of_block && !end_of_row |=> in_stall ##1 in_stall ##1 !in_stall)
        else $error("block close timing wrong");

    // A row end keeps the input stalled while the row result is formed.
    a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && end_of_row |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("input accepted while a row result is being formed");

    // A new result appears only out of the row-end sequence.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result produced outside a row end");

endmodule

bind q4_block_dot_accumulate q4bda_checker u_checker (.*);

`default_nettype wire

// File: dv/tb_q4_block_dot_accumulate.sv
module tb_q4_block_dot_accumulate;
    timeunit 1ns;
    timeprecision 1ps;

    import q4bda_pkg::*;

    // Nominal block length in bytes. Block boundaries come only from
    // end_of_block and end_of_row, so this number only shapes the stimulus.
    localparam int unsigned NOMINAL_PAIRS   = 16;
    localparam int unsigned IDLE_PERCENT    = 28;
    localparam int unsigned RANDOM_ITEMS    = 740;
    localparam int unsigned MIN_RANDOM_ROWS = 20;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam int unsigned DRAIN_CYCLES    = 16;

    // Rows that drive the block partial into saturation at both limits.
    // 36 bytes of full-scale products pin a block partial at its limit.
    localparam int unsigned SAT_BLOCK_BYTES = 36;
    localparam int unsigned SAT_BLOCKS      = 2;

    // Saturation limits of the block partial, the row accumulator and the
    // emitted row_dot, all as 64-bit signed values.
    localparam longint PART_MAX = (64'sd1 <<< (PARTIAL_W - 1)) - 1;
    localparam longint PART_MIN = -(64'sd1 <<< (PARTIAL_W - 1));
    localparam longint ACC_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint ACC_MIN  = 64'sh8000_0000_0000_0000;
    localparam longint DOT_MAX  = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint DOT_MIN  = -(64'sd1 <<< (OUT_W - 1));

    typedef logic signed [ACT_W-1:0]   act_t;
    typedef logic signed [SCALE_W-1:0] scale_t;
    typedef logic signed [OUT_W-1:0]   row_dot_t;

    // Scoreboard: keeps its own copy of the block partial and the row
    // accumulator, folds every accepted byte into them, and queues one
    // expected row_dot for each byte that ends a row.
    class row_dot_scoreboard;
        longint      block_partial = 0;
        longint      row_acc = 0;
        row_dot_t    expected_dots[$];
        int unsigned mismatches = 0;

        function void accumulate_byte(logic [BYTE_W-1:0] weights, act_t a_even, act_t a_odd,
                                      scale_t scale, logic close_block, logic close_row);
            longint w_lo;
            longint w_hi;
            longint sum;
            longint scaled;
            longint total;
            w_lo = longint'(weights[NIB_W-1:0]) - 8;
            w_hi = longint'(weights[BYTE_W-1:NIB_W]) - 8;
            sum = block_partial + w_lo * longint'(a_even) + w_hi * longint'(a_odd);
            block_partial = (sum > PART_MAX) ? PART_MAX : (sum < PART_MIN) ? PART_MIN : sum;
            if (close_block || close_row)
            begin
                scaled = block_partial * longint'(scale);
                total = row_acc + scaled;
                if (row_acc[63] == scaled[63] && total[63] != row_acc[63])
                    total = scaled[63] ? ACC_MIN : ACC_MAX;
                row_acc = total;
                block_partial = 0;
            end
            if (close_row)
            begin
                total = (row_acc > DOT_MAX) ? DOT_MAX : (row_acc < DOT_MIN) ? DOT_MIN : row_acc;
                expected_dots.push_back(total[OUT_W-1:0]);
                row_acc = 0;
            end
        endfunction

        function void check_row_dot(row_dot_t got);
            row_dot_t want;
            if (expected_dots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("row_dot %0d arrived with no row pending", got);
                return;
            end
            want = expected_dots.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("row_dot mismatch: expected %0d, actual %0d", want, got);
            end
        endfunction
    endclass

    // Every input starts at a known value; reset is held from time zero.
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] packed_byte = '0;
    act_t              act_even = '0;
    act_t              act_odd = '0;
    scale_t            block_scale = '0;
    logic              end_of_block = 1'b0;
    logic              end_of_row = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    row_dot_t          row_dot;

    row_dot_scoreboard sb = new;

    // While steady is set, neither the byte sender nor the result taker
    // inserts idle cycles, so the block runs at its full rate for a while.
    bit          steady = 1'b0;
    int unsigned sent = 0;
    int unsigned rows = 0;

    q4_block_dot_accumulate u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .packed_byte  (packed_byte),
        .act_even     (act_even),
        .act_odd      (act_odd),
        .block_scale  (block_scale),
        .end_of_block (end_of_block),
        .end_of_row   (end_of_row),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .row_dot      (row_dot)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard limit on the run: far above the slowest legal run, in which every
    // block closes on a single byte and each result waits out long stalls.
    initial
    begin
        #30_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Random 16-bit fixed-point value, with the full-scale corners, zero and
    // minus one showing up more often than a flat draw would give them.
    function automatic act_t random_q16();
        case ($urandom_range(15, 0))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return 16'shFFFF;
            default: return act_t'($urandom);
        endcase
    endfunction

    // Random packed weight byte; 0x00 and 0xFF put both nibbles at an extreme.
    function automatic logic [BYTE_W-1:0] random_weights();
        case ($urandom_range(15, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return BYTE_W'($urandom_range(255, 0));
        endcase
    endfunction

    // One input transfer. Idle cycles come first, then the byte is held on
    // the bus until a rising edge sees in_valid high with in_stall low. The
    // scoreboard is told at that same edge. Valid is left high on return so
    // that a following byte can go out back to back without a drop.
    task automatic send_byte(input logic [BYTE_W-1:0] weights, input act_t a_even,
                             input act_t a_odd, input scale_t scale,
                             input logic close_block, input logic close_row);
        while (!steady && $urandom_range(99, 0) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        packed_byte  <= weights;
        act_even     <= a_even;
        act_odd      <= a_odd;
        block_scale  <= scale;
        end_of_block <= close_block;
        end_of_row   <= close_row;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.accumulate_byte(weights, a_even, a_odd, scale, close_block, close_row);
    endtask

    // A row of SAT_BLOCKS long blocks whose bytes all have both nibbles at -8.
    // Each block pins the partial at one of its limits before it is scaled.
    task automatic send_saturating_row(input act_t act, input scale_t scale);
        int unsigned blk;
        int unsigned idx;
        for (blk = 0; blk < SAT_BLOCKS; blk++)
            for (idx = 1; idx <= SAT_BLOCK_BYTES; idx++)
                send_byte(8'h00, act, act, scale, idx == SAT_BLOCK_BYTES,
                          idx == SAT_BLOCK_BYTES && blk == SAT_BLOCKS - 1);
    endtask

    // A random row of one to three blocks. Most blocks have the nominal
    // length; some are short, and some run long enough to saturate the
    // partial sum. A stray end_of_block now and then splits a block early,
    // and about one row in five ends without closing its last block, so that
    // end_of_row has to close it.
    task automatic send_random_row();
        int unsigned blocks;
        int unsigned len;
        int unsigned blk;
        int unsigned idx;
        int unsigned pick;
        logic        open_end;
        logic        last;
        logic        close_block;
        blocks   = $urandom_range(3, 1);
        open_end = $urandom_range(99, 0) < 20;
        for (blk = 0; blk < blocks; blk++)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 70)
                len = NOMINAL_PAIRS;
            else if (pick < 88)
                len = $urandom_range(NOMINAL_PAIRS - 1, 1);
            else
                len = $urandom_range(3 * NOMINAL_PAIRS, NOMINAL_PAIRS + 1);
            for (idx = 1; idx <= len; idx++)
            begin
                last = (idx == len);
                if (last)
                    close_block = !(open_end && blk == blocks - 1);
                else
                    close_block = ($urandom_range(99, 0) < 4);
                send_byte(random_weights(), random_q16(), random_q16(), random_q16(),
                          close_block, last && blk == blocks - 1);
                sent++;
            end
        end
    endtask

    // Result side. A row_dot transfer is taken at each rising edge where
    // out_valid is high and out_stall low; out_stall is then redrawn for the
    // next cycle, so stalls land on every phase of the output handshake.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_row_dot(row_dot);
        out_stall <= !steady && ($urandom_range(99, 0) < IDLE_PERCENT);
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full-scale activations and scales on short blocks, covering
        // both extremes of each nibble and each signed field.
        send_byte(8'h00, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1, 1'b0);
        send_byte(8'hFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1, 1'b0);
        send_byte(8'h0F, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
        send_byte(8'hF0, 16'sh7FFF, 16'sh8000, 16'sh8000, 1'b1, 1'b1);

        // Both nibbles equal to 8 are zero weights: the row comes out zero.
        send_byte(8'h88, 16'sh1234, 16'shBCDF, 16'sh1000, 1'b1, 1'b1);

        // A one-byte row flagged with end_of_row alone.
        send_byte(8'h5A, 16'sh0100, 16'shFF00, 16'sh1000, 1'b0, 1'b1);

        // Row end without block end: the open block is closed with the scale
        // carried by the row-ending byte, not by the bytes before it.
        send_byte(8'h3C, 16'sh0480, 16'shF9C0, 16'sh0000, 1'b0, 1'b0);
        send_byte(8'hC3, 16'sh7FFF, 16'sh8000, 16'sh0000, 1'b0, 1'b0);
        send_byte(8'h71, 16'sh0001, 16'shFFFF, 16'sh2000, 1'b0, 1'b1);

        // A block closed with a zero scale adds nothing to the row.
        send_byte(8'h17, 16'sh4000, 16'shC000, 16'sh0000, 1'b1, 1'b0);
        send_byte(8'h9E, 16'sh0003, 16'sh0005, 16'shFFFF, 1'b1, 1'b1);

        // Row ends on consecutive bytes, so a second result is formed while
        // the first may still wait in the output register.
        send_byte(8'h01, 16'sh7FFF, 16'sh0080, 16'sh7FFF, 1'b1, 1'b1);
        send_byte(8'hFE, 16'sh8000, 16'shFF80, 16'sh8000, 1'b0, 1'b1);
        send_byte(8'h80, 16'sh2000, 16'shE000, 16'sh0400, 1'b1, 1'b1);

        // Partial overflow: one row with the partial pinned at its minimum
        // and a positive result, one with the partial pinned at its maximum
        // and a negative result.
        send_saturating_row(16'sh7FFF, 16'sh8000);
        send_saturating_row(16'sh8000, 16'sh8000);

        // Random rows, with one stretch where neither side idles.
        while (sent < RANDOM_ITEMS || rows < MIN_RANDOM_ROWS)
        begin
            steady = (sent >= 300 && sent < 450);
            send_random_row();
            rows++;
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // Wait for the last rows, then give the block time to show any
        // transfer it should not make.
        while (sb.expected_dots.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_dots.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
rtl/core/q4bda_pkg.sv
rtl/core/q4bda_ctrl.sv
rtl/core/q4bda_datapath.sv
rtl/core/q4_block_dot_accumulate.sv
rtl/core/q4bda_checker.sv
dv/tb_q4_block_dot_accumulate.sv
